/* rtl/core/bu2x_pkg.sv */
// shared types and constants of the 2x bilinear upscaler
package bu2x_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int CHANNELS   = 3;
  localparam int CH_W       = 8;
  localparam int PX_W       = CHANNELS * CH_W;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_W      = 11;
  localparam int CFG_AW     = 1;
  localparam int COORD_W    = 11;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } px_t;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic               last_of_run;
  } out_item_t;

  // one classified input pixel with its neighbourhood
  typedef struct packed {
    px_t              pix;
    px_t              left;
    px_t              above_left;
    px_t              above;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             first_row;
    logic             last_row;
    logic             first_col;
    logic             last_col;
  } job_t;

endpackage

/* rtl/core/bu2x_ram.sv */
// generic single write, single read ram with registered read (read-first)
module bu2x_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/bu2x_front.sv */
// front end: size registers, raster counters, line buffer and job build
module bu2x_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bu2x_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [bu2x_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bu2x_pkg::in_item_t            in_data,
  output logic                          job_valid,
  input  logic                          job_ready,
  output bu2x_pkg::job_t                job
);
  import bu2x_pkg::*;

  logic [CFG_W-1:0] width_r, height_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W:0]   eff_w, w_m1;
  logic [ROW_W:0]   eff_h, h_m1;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;
  logic             accept, push, at_col_end, at_row_end;
  px_t              pix, left_r, al_r, s1_pix_r, s1_left_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_valid_r, s1_last_row_r, s1_last_col_r;
  logic [PX_W-1:0]  above_raw;

  // clamp sizes into the supported range
  always_comb begin
    if (width_r < CFG_W'(2)) begin
      eff_w = (COL_W+1)'(2);
    end else if (int'(width_r) > MAX_WIDTH) begin
      eff_w = (COL_W+1)'(MAX_WIDTH);
    end else begin
      eff_w = (COL_W+1)'(width_r);
    end
    if (height_r < CFG_W'(2)) begin
      eff_h = (ROW_W+1)'(2);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      eff_h = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      eff_h = (ROW_W+1)'(height_r);
    end
  end

  assign w_m1       = eff_w - 1'b1;
  assign h_m1       = eff_h - 1'b1;
  assign col_last   = w_m1[COL_W-1:0];
  assign row_last   = h_m1[ROW_W-1:0];
  assign at_col_end = (col_r == col_last);
  assign at_row_end = (row_r == row_last);

  assign pix      = {in_data.in_blue, in_data.in_green, in_data.in_red};
  assign push     = s1_valid_r & job_ready;
  assign in_ready = ~s1_valid_r | job_ready;
  assign accept   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RST;
      height_r   <= HEIGHT_RST;
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_WIDTH:  width_r  <= cfg_wdata;
          REG_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        if (at_col_end) begin
          col_r <= '0;
          row_r <= at_row_end ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (push) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r      <= pix;
      s1_left_r     <= left_r;
      s1_col_r      <= col_r;
      s1_row_r      <= row_r;
      s1_last_col_r <= at_col_end;
      s1_last_row_r <= at_row_end;
      left_r        <= pix;
    end
    if (push) begin
      al_r <= px_t'(above_raw);
    end
  end

  // previous input row; read and overwritten at the same column
  bu2x_ram #(
    .WIDTH (PX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_r),
    .wr_data (PX_W'(pix)),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (above_raw)
  );

  assign job_valid = s1_valid_r;
  always_comb begin
    job.pix        = s1_pix_r;
    job.left       = s1_left_r;
    job.above_left = al_r;
    job.above      = px_t'(above_raw);
    job.row        = s1_row_r;
    job.col        = s1_col_r;
    job.first_row  = (s1_row_r == '0);
    job.last_row   = s1_last_row_r;
    job.first_col  = (s1_col_r == '0);
    job.last_col   = s1_last_col_r;
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (col_r <= col_last))
    else $error("column counter beyond image width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (row_r <= row_last))
    else $error("row counter beyond image height");

  a_above_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !job_ready) |=> $stable(above_raw))
    else $error("line buffer data lost while job stalled");

endmodule

/* rtl/core/bu2x_queue.sv */
// short job queue between front and back end
module bu2x_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  bu2x_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bu2x_pkg::job_t pop_data
);
  import bu2x_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r;
  logic            push, pop;

  assign push_ready = (cnt_r != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue fill above depth");

endmodule

/* rtl/core/bu2x_back.sv */
// back end: walks the output block of one job and emits one pixel a cycle while the output is not stalled
module bu2x_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  bu2x_pkg::job_t        job,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bu2x_pkg::out_item_t   out_data
);
  import bu2x_pkg::*;

  function automatic px_t avg_px(px_t a, px_t b);
    logic [CH_W:0] sr, sg, sb;
    px_t           res;
    sr = {1'b0, a.red}   + {1'b0, b.red};
    sg = {1'b0, a.green} + {1'b0, b.green};
    sb = {1'b0, a.blue}  + {1'b0, b.blue};
    res.red   = sr[CH_W:1];
    res.green = sg[CH_W:1];
    res.blue  = sb[CH_W:1];
    return res;
  endfunction

  logic       act_r, out_valid_r;
  logic [1:0] i_r, j_r, cur_i, cur_j, start_i, end_i, start_j, end_j;
  logic       load, emit, done;
  px_t        hb, va, ctr, sel;
  out_item_t  out_data_r, nxt;

  // offsets: row 2r-1+i, column 2c-1+j
  always_comb begin
    start_i = job.first_row ? 2'd1 : 2'd0;
    end_i   = job.last_row  ? 2'd2 : 2'd1;
    start_j = job.first_col ? 2'd1 : 2'd0;
    end_j   = job.last_col  ? 2'd2 : 2'd1;
    cur_i   = act_r ? i_r : start_i;
    cur_j   = act_r ? j_r : start_j;
  end

  assign load      = ~out_valid_r | out_ready;
  assign emit      = job_valid & load;
  assign done      = (cur_i == end_i) && (cur_j == end_j);
  assign job_ready = emit & done;

  always_comb begin
    hb  = avg_px(job.left, job.pix);
    va  = avg_px(job.above, job.pix);
    ctr = avg_px(avg_px(job.above_left, job.above), hb);
    if (cur_i == 2'd0) begin
      sel = (cur_j == 2'd0) ? ctr : va;
    end else begin
      sel = (cur_j == 2'd0) ? hb : job.pix;
    end
    nxt.out_row     = COORD_W'({job.row, 1'b0}) + COORD_W'(cur_i) - COORD_W'(1);
    nxt.out_col     = COORD_W'({job.col, 1'b0}) + COORD_W'(cur_j) - COORD_W'(1);
    nxt.out_red     = sel.red;
    nxt.out_green   = sel.green;
    nxt.out_blue    = sel.blue;
    nxt.last_of_run = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        if (done) begin
          act_r <= 1'b0;
        end else begin
          act_r <= 1'b1;
          if (cur_j == end_j) begin
            i_r <= cur_i + 1'b1;
            j_r <= start_j;
          end else begin
            i_r <= cur_i;
            j_r <= cur_j + 1'b1;
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_active_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> job_valid)
    else $error("walking a block with no job at the queue head");

  a_stay_active: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !done) |=> act_r)
    else $error("job dropped before its last pixel");

endmodule

/* rtl/core/bilinear_upscale_2x_core.sv */
// top level of the streaming 2x bilinear rgb upscaler
//
//   channel  direction  handshake           payload
//   in_      sink       in_valid/in_ready   in_item_t: one low-res pixel
//   out_     source     out_valid/out_ready out_item_t: one enlarged pixel
//   cfg_     sink       cfg_we              cfg_addr, cfg_wdata: size regs
//
// the back end emits one result per cycle while the output is not stalled;
// an item has 1 to 9 results, four for an interior pixel
// an item passes through the front's stage register (line buffer read and
// job build), a queue entry and the back end's output register on its way out
// synchronous active-low reset; the line buffer needs no clearing pass
// a two-entry job queue lets the input keep flowing while the output stalls, until the queue is full
module bilinear_upscale_2x_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bu2x_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [bu2x_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bu2x_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bu2x_pkg::out_item_t           out_data
);
  import bu2x_pkg::*;

  // front to queue
  logic job_valid, job_ready;
  job_t job;
  // queue to back
  logic head_valid, head_ready;
  job_t head;

  // counts columns and rows, reads the pixel above from the line buffer and
  // packs the neighbourhood of each pixel into a job
  bu2x_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  // decouples the front, which builds one job per pixel, from the back, which emits up to nine results per job
  bu2x_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_data  (job),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_data   (head)
  );

  // walks rows 2r-1..2r+1 and columns 2c-1..2c+1 as present, in raster order,
  // averaging on the fly into the output register
  bu2x_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (head_valid),
    .job_ready (head_ready),
    .job       (head),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
